>>> hdl/mfr_pkg.sv
// Shared types, codes and helper functions for the multiblock frame reassembler.
// No dependencies; used by scoped names in the controller, sequencer and top, imported by the checker and testbench.
package mfr_pkg;

    // Payload widths
    localparam int DATA_W     = 64;
    localparam int FRAME_W    = 8;
    localparam int FN_W       = 2;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int MAX_BLOCKS = 16;

    // Stream packing
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    // Multiframe numbering and control-channel slots
    localparam int FRAMES_PER_MF = 200;
    localparam int CTRL_PERIOD   = 25;
    localparam int CTRL_RESIDUE  = 14;
    localparam int CTRL_SLOTS    = (256 - CTRL_RESIDUE + CTRL_PERIOD - 1) / CTRL_PERIOD;

    // Frame function codes
    localparam logic [FN_W-1:0] FN_SINGLE = 2'd0;
    localparam logic [FN_W-1:0] FN_FIRST  = 2'd1;
    localparam logic [FN_W-1:0] FN_CONT   = 2'd2;
    localparam logic [FN_W-1:0] FN_END    = 2'd3;

    typedef enum logic [1:0] {
        KIND_BLOCK = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_SEQ   = 2'd2,
        KIND_PAR   = 2'd3
    } kind_t;

    // What the sequencer must do with an accepted word
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_IMM   = 2'd1,
        ACT_EMIT  = 2'd2,
        ACT_CHECK = 2'd3
    } act_t;

    typedef struct packed {
        act_t                act;
        kind_t               kind;
        logic [DATA_W-1:0]   data;
        logic                seg_reset;
        logic [FRAME_W-1:0]  start_frame;
        logic                start_known;
        logic [FRAME_W-1:0]  rec_frame;
        logic                rec_valid;
        logic [CNT_W-1:0]    count;
        logic [IDX_W-1:0]    emit_last;
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        logic [DATA_W-1:0]   data;
        logic [IDX_W-1:0]    index;
        logic [FRAME_W-1:0]  start_frame;
        logic                start_known;
        logic                seg_reset;
        logic [FRAME_W-1:0]  rec_frame;
        logic                rec_valid;
        logic                last;
    } res_t;

    // Reverse the bit order inside every octet
    function automatic logic [DATA_W-1:0] octet_reverse(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[(i & ~7) | (7 - (i & 7))];
        end
        return r;
    endfunction

    // True for frame numbers that are 14 modulo 25
    function automatic logic is_ctrl_frame(input logic [FRAME_W-1:0] fno);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < CTRL_SLOTS; k++) begin
            if (fno == FRAME_W'(CTRL_RESIDUE + k * CTRL_PERIOD)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> hdl/mfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/mfr_msg_ctrl.sv
// Message phase machine: classifies each frame, tracks block count and start frame,
// and issues block-store writes and sequencer commands. Depends on mfr_pkg.
module mfr_msg_ctrl #(
    parameter int STORE_CAP = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [mfr_pkg::DATA_W-1:0]     data,
    input  logic [mfr_pkg::FRAME_W-1:0]    frame_num,
    input  logic                           frame_num_known,
    input  logic [mfr_pkg::FN_W-1:0]       frame_function,
    output mfr_pkg::cmd_t                  cmd,
    output logic                           wr_en,
    output logic [$clog2(STORE_CAP)-1:0]   wr_addr
);

    localparam int AW = $clog2(STORE_CAP);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_FIRST = 5'b00010,
        PH_CONT  = 5'b00100,
        PH_PAR   = 5'b01000,
        PH_LONG  = 5'b10000
    } phase_t;

    phase_t                          phase_reg,  phase_next;
    logic [mfr_pkg::CNT_W-1:0]       count_reg,  count_next;
    logic [mfr_pkg::FRAME_W-1:0]     sf_reg,     sf_next;
    logic                            sk_reg,     sk_next;

    logic                            fits;
    logic [mfr_pkg::FRAME_W:0]       rec_sum;
    logic [mfr_pkg::FRAME_W-1:0]     rec_frame;

    assign fits = (count_reg < mfr_pkg::CNT_W'(STORE_CAP));

    // Final frame number of a long message: start + blocks - 1, wrapped at 200
    assign rec_sum   = {1'b0, sf_reg} + (mfr_pkg::FRAME_W + 1)'(count_reg);
    assign rec_frame = (rec_sum >= (mfr_pkg::FRAME_W + 1)'(mfr_pkg::FRAMES_PER_MF))
                     ? mfr_pkg::FRAME_W'(rec_sum - (mfr_pkg::FRAME_W + 1)'(mfr_pkg::FRAMES_PER_MF))
                     : rec_sum[mfr_pkg::FRAME_W-1:0];

    // Decode the frame against the current phase
    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        sf_next         = sf_reg;
        sk_next         = sk_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        cmd.act         = mfr_pkg::ACT_NONE;
        cmd.kind        = mfr_pkg::KIND_SEQ;
        cmd.data        = '0;
        cmd.seg_reset   = 1'b1;
        cmd.start_frame = sf_reg;
        cmd.start_known = sk_reg;
        cmd.rec_frame   = '0;
        cmd.rec_valid   = 1'b0;
        cmd.count       = count_reg;
        cmd.emit_last   = '0;

        if (frame_num_known && mfr_pkg::is_ctrl_frame(frame_num))
        begin
            // Control-channel frame: pass through, state untouched
            cmd.act         = mfr_pkg::ACT_IMM;
            cmd.kind        = mfr_pkg::KIND_CTRL;
            cmd.data        = data;
            cmd.seg_reset   = 1'b0;
            cmd.start_frame = frame_num;
            cmd.start_known = frame_num_known;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    unique case (frame_function) inside
                        mfr_pkg::FN_SINGLE, mfr_pkg::FN_FIRST:
                        begin
                            cmd.act    = mfr_pkg::ACT_IMM;
                            phase_next = PH_IDLE;
                        end
                        mfr_pkg::FN_CONT:
                        begin
                            if (fits)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                phase_next = PH_CONT;
                            end
                            else
                            begin
                                cmd.act    = mfr_pkg::ACT_IMM;
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            // Two-block message complete
                            wr_en         = 1'b1;
                            wr_addr       = AW'(1);
                            cmd.act       = mfr_pkg::ACT_EMIT;
                            cmd.kind      = mfr_pkg::KIND_BLOCK;
                            cmd.seg_reset = 1'b0;
                            cmd.emit_last = mfr_pkg::IDX_W'(1);
                            phase_next    = PH_IDLE;
                        end
                    endcase
                end
                PH_CONT, PH_LONG:
                begin
                    if (frame_function == mfr_pkg::FN_SINGLE ||
                        frame_function == mfr_pkg::FN_FIRST)
                    begin
                        cmd.act       = mfr_pkg::ACT_IMM;
                        cmd.seg_reset = (phase_reg != PH_CONT);
                        phase_next    = PH_IDLE;
                    end
                    else if (!fits)
                    begin
                        cmd.act    = mfr_pkg::ACT_IMM;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        phase_next = (frame_function == mfr_pkg::FN_CONT) ? PH_PAR : PH_LONG;
                    end
                end
                PH_PAR:
                begin
                    if (frame_function != mfr_pkg::FN_FIRST || !fits)
                    begin
                        cmd.act    = mfr_pkg::ACT_IMM;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // Store the parity block, then check and emit
                        wr_en         = 1'b1;
                        count_next    = count_reg + 1'b1;
                        cmd.act       = mfr_pkg::ACT_CHECK;
                        cmd.kind      = mfr_pkg::KIND_BLOCK;
                        cmd.seg_reset = 1'b0;
                        cmd.count     = count_reg + 1'b1;
                        cmd.emit_last = mfr_pkg::IDX_W'(count_reg - 1'b1);
                        cmd.rec_valid = !frame_num_known && sk_reg;
                        cmd.rec_frame = (!frame_num_known && sk_reg) ? rec_frame : '0;
                        phase_next    = PH_IDLE;
                    end
                end
                default:
                begin
                    // Idle: restart the message at this frame
                    count_next      = '0;
                    sf_next         = frame_num;
                    sk_next         = frame_num_known;
                    cmd.start_frame = frame_num;
                    cmd.start_known = frame_num_known;
                    phase_next      = PH_IDLE;
                    wr_addr         = '0;
                    unique case (frame_function) inside
                        mfr_pkg::FN_SINGLE:
                        begin
                            wr_en         = 1'b1;
                            cmd.act       = mfr_pkg::ACT_IMM;
                            cmd.kind      = mfr_pkg::KIND_BLOCK;
                            cmd.data      = data;
                            cmd.seg_reset = 1'b0;
                        end
                        mfr_pkg::FN_FIRST:
                        begin
                            wr_en      = 1'b1;
                            count_next = mfr_pkg::CNT_W'(1);
                            phase_next = PH_FIRST;
                        end
                        default:
                        begin
                            cmd.act = mfr_pkg::ACT_IMM;
                        end
                    endcase
                end
            endcase
        end
    end

    // Advance the message state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            sf_reg    <= '0;
            sk_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sf_reg    <= sf_next;
            sk_reg    <= sk_next;
        end
    end

    // Assertions
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mfr_pkg::CNT_W'(STORE_CAP))
        else $error("block count beyond store capacity");

    a_idle_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IDLE && !(frame_num_known && mfr_pkg::is_ctrl_frame(frame_num)))
        |=> (sf_reg == $past(frame_num) && sk_reg == $past(frame_num_known)))
        else $error("start frame not reloaded in idle");

    a_check_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.act == mfr_pkg::ACT_CHECK) |-> (count_reg >= mfr_pkg::CNT_W'(3)))
        else $error("parity check on too short a message");

endmodule

>>> hdl/mfr_sweep.sv
// Block-store sequencer: XOR parity sweep over the stored blocks and emission of
// message blocks one at a time through an output register. Depends on mfr_pkg.
module mfr_sweep #(
    parameter int STORE_CAP = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  mfr_pkg::cmd_t                 cmd,
    output logic                          ready,
    output logic                          rd_en,
    output logic [$clog2(STORE_CAP)-1:0]  rd_addr,
    input  logic [mfr_pkg::DATA_W-1:0]    rd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mfr_pkg::res_t                 res
);

    localparam int AW = $clog2(STORE_CAP);

    typedef enum logic [4:0] {
        SW_IDLE = 5'b00001,
        SW_XOR  = 5'b00010,
        SW_RD   = 5'b00100,
        SW_LOAD = 5'b01000,
        SW_OUT  = 5'b10000
    } sweep_state_t;

    sweep_state_t                  state_reg, state_next;
    logic [mfr_pkg::CNT_W-1:0]     idx_reg,   idx_next;
    logic                          pend_reg,  pend_next;
    logic [mfr_pkg::DATA_W-1:0]    acc_reg,   acc_next;
    mfr_pkg::cmd_t                 cmd_reg,   cmd_next;
    mfr_pkg::res_t                 res_reg,   res_next;

    assign ready     = (state_reg == SW_IDLE);
    assign out_valid = (state_reg == SW_OUT);
    assign res       = res_reg;
    assign rd_addr   = idx_reg[AW-1:0];

    // Sequence the sweep and the emission
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;

        unique case (state_reg)
            SW_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    acc_next = '0;
                    unique case (cmd.act)
                        mfr_pkg::ACT_IMM:
                        begin
                            res_next.kind        = cmd.kind;
                            res_next.data        = cmd.data;
                            res_next.index       = '0;
                            res_next.start_frame = cmd.start_frame;
                            res_next.start_known = cmd.start_known;
                            res_next.seg_reset   = cmd.seg_reset;
                            res_next.rec_frame   = cmd.rec_frame;
                            res_next.rec_valid   = cmd.rec_valid;
                            res_next.last        = 1'b1;
                            state_next           = SW_OUT;
                        end
                        mfr_pkg::ACT_EMIT:
                        begin
                            state_next = SW_RD;
                        end
                        mfr_pkg::ACT_CHECK:
                        begin
                            state_next = SW_XOR;
                        end
                        default:
                        begin
                            state_next = SW_IDLE;
                        end
                    endcase
                end
            end
            SW_XOR:
            begin
                // Fold one stored block per cycle into the parity accumulator
                if (pend_reg)
                begin
                    acc_next = acc_reg ^ rd_data;
                end
                if (idx_reg < cmd_reg.count)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    idx_next = '0;
                    if (acc_reg != '0)
                    begin
                        res_next.kind        = mfr_pkg::KIND_PAR;
                        res_next.data        = '0;
                        res_next.index       = '0;
                        res_next.start_frame = cmd_reg.start_frame;
                        res_next.start_known = cmd_reg.start_known;
                        res_next.seg_reset   = 1'b0;
                        res_next.rec_frame   = '0;
                        res_next.rec_valid   = 1'b0;
                        res_next.last        = 1'b1;
                        state_next           = SW_OUT;
                    end
                    else
                    begin
                        state_next = SW_RD;
                    end
                end
            end
            SW_RD:
            begin
                rd_en      = 1'b1;
                state_next = SW_LOAD;
            end
            SW_LOAD:
            begin
                res_next.kind        = mfr_pkg::KIND_BLOCK;
                res_next.data        = rd_data;
                res_next.index       = idx_reg[mfr_pkg::IDX_W-1:0];
                res_next.start_frame = cmd_reg.start_frame;
                res_next.start_known = cmd_reg.start_known;
                res_next.seg_reset   = 1'b0;
                res_next.rec_frame   = cmd_reg.rec_frame;
                res_next.rec_valid   = cmd_reg.rec_valid;
                res_next.last        = (idx_reg == {1'b0, cmd_reg.emit_last});
                state_next           = SW_OUT;
            end
            SW_OUT:
            begin
                if (out_ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = SW_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = SW_RD;
                    end
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    // Assertions
    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(rd_en))
        else $error("accumulate without a preceding read");

    a_xor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SW_XOR) |-> (idx_reg <= cmd_reg.count))
        else $error("parity sweep ran past the block count");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SW_LOAD) |-> (idx_reg <= {1'b0, cmd_reg.emit_last}))
        else $error("emission ran past the final block");

    a_parity_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SW_OUT && res_reg.kind == mfr_pkg::KIND_PAR) |-> res_reg.last)
        else $error("parity error word not marked last");

    a_check_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.act == mfr_pkg::ACT_CHECK) |=> (state_reg == SW_XOR && !pend_reg))
        else $error("parity check did not start the sweep");

endmodule

>>> hdl/multiblock_frame_reassembler_top.sv
// Output: a pass-through, single-block or error result is on m_tdata in the cycle after accept;
// a frame that only extends a message gives no result and leaves s_tready high. Each block of a
// two-block message passes SW_RD, SW_LOAD and SW_OUT; a long message runs a parity sweep on the
// single read port, then emits its blocks that way or a parity error word (plus any m_tready stall).
// Throughput: one frame at a time; s_tready returns once the last result word is taken.
// Reset (rst_n, async, active low) clears the phase, count, start registers and sequencer;
// the block store is not cleared.
module multiblock_frame_reassembler_top #(
    parameter int BLOCK_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_bits[63:0], frame_num[71:64]
    input  logic [mfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // frame_num_known[0], frame_function[2:1]
    input  logic [mfr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // block_data[63:0], block_index[67:64], start_frame[75:68], start_known[76],
    // seg_reset[77], recovered_frame[85:78], recovered_valid[86], zero pad[87]
    output logic [mfr_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic [mfr_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    localparam int STORE_CAP = (BLOCK_SLOTS < mfr_pkg::MAX_BLOCKS) ? BLOCK_SLOTS
                                                                   : mfr_pkg::MAX_BLOCKS;
    localparam int AW = $clog2(STORE_CAP);

    logic                           accept;
    logic [mfr_pkg::DATA_W-1:0]     data;
    mfr_pkg::cmd_t                  cmd;
    mfr_pkg::res_t                  res;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [mfr_pkg::DATA_W-1:0]     rd_data;
    logic                           ready;

    // Take a word when the sequencer is idle
    assign s_tready = ready;
    assign accept   = s_tvalid && ready;

    // Reorder bits within each octet
    assign data = mfr_pkg::octet_reverse(s_tdata[mfr_pkg::DATA_W-1:0]);

    mfr_msg_ctrl #(
        .STORE_CAP (STORE_CAP)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data            (data),
        .frame_num       (s_tdata[mfr_pkg::DATA_W +: mfr_pkg::FRAME_W]),
        .frame_num_known (s_tuser[0]),
        .frame_function  (s_tuser[1 +: mfr_pkg::FN_W]),
        .cmd             (cmd),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr)
    );

    mfr_ram #(
        .WIDTH (mfr_pkg::DATA_W),
        .DEPTH (STORE_CAP)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en && accept),
        .wr_addr (wr_addr),
        .wr_data (data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mfr_sweep #(
        .STORE_CAP (STORE_CAP)
    ) u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .ready     (ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    // Pack the result word
    assign m_tdata = {1'b0, res.rec_valid, res.rec_frame, res.seg_reset, res.start_known,
                      res.start_frame, res.index, res.data};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

>>> dv/mfr_reassembly_checker.sv
// Checker for the multiblock frame reassembler: predicts result words from accepted frames
// and compares them against the master-side stream. Depends on mfr_pkg for codes and widths.
module mfr_reassembly_checker #(
    parameter int BLOCK_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // frame_bits[63:0], frame_num[71:64]
    input  logic [mfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // frame_num_known[0], frame_function[2:1]
    input  logic [mfr_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // block_data[63:0], block_index[67:64], start_frame[75:68], start_known[76],
    // seg_reset[77], recovered_frame[85:78], recovered_valid[86], zero pad[87]
    input  logic [mfr_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[1:0]
    input  logic [mfr_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mfr_pkg::*;

    localparam int STORE_DEPTH = (BLOCK_SLOTS < MAX_BLOCKS) ? BLOCK_SLOTS : MAX_BLOCKS;

    // Message assembly phases
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_OPENED     = 3'd1,
        ST_SECOND     = 3'd2,
        ST_PARITY_DUE = 3'd3,
        ST_BODY       = 3'd4
    } msg_phase_t;

    typedef struct {
        kind_t               kind;
        logic [DATA_W-1:0]   data;
        logic [IDX_W-1:0]    index;
        logic [FRAME_W-1:0]  start_frame;
        logic                start_known;
        logic                seg_reset;
        logic [FRAME_W-1:0]  rec_frame;
        logic                rec_valid;
        logic                last;
    } result_word_t;

    msg_phase_t          msg_phase = ST_IDLE;
    int                  blocks_held = 0;
    logic [FRAME_W-1:0]  start_no = '0;
    logic                start_no_known = 1'b0;
    logic [DATA_W-1:0]   held_blocks [BLOCK_SLOTS];
    result_word_t        expected_words [$];
    int                  mismatches = 0;

    // Reverse the bit order within each octet of a frame
    function automatic logic [DATA_W-1:0] swap_octet_bits(input logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] swapped;
        for (int b = 0; b < DATA_W / 8; b++) begin
            for (int j = 0; j < 8; j++) begin
                swapped[8*b + j] = raw[8*b + 7 - j];
            end
        end
        return swapped;
    endfunction

    task automatic emit(input kind_t kind, input logic [DATA_W-1:0] data,
                        input logic [IDX_W-1:0] index, input logic [FRAME_W-1:0] sf,
                        input logic sk, input logic sr, input logic [FRAME_W-1:0] rf,
                        input logic rv);
        result_word_t w;
        w.kind        = kind;
        w.data        = data;
        w.index       = index;
        w.start_frame = sf;
        w.start_known = sk;
        w.seg_reset   = sr;
        w.rec_frame   = rf;
        w.rec_valid   = rv;
        w.last        = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic seq_error(input logic sr);
        emit(KIND_SEQ, '0, '0, start_no, start_no_known, sr, '0, 1'b0);
        msg_phase = ST_IDLE;
    endtask

    // Append a block to the store; refuse it once the store is full
    function automatic bit stash(input logic [DATA_W-1:0] word);
        if (blocks_held >= STORE_DEPTH) begin
            return 1'b0;
        end
        held_blocks[blocks_held] = word;
        blocks_held++;
        return 1'b1;
    endfunction

    // Advance the assembly state by one frame and queue the words it releases
    task automatic predict_reassembly(input logic [DATA_W-1:0] raw,
                                      input logic [FRAME_W-1:0] fno,
                                      input logic known, input logic [FN_W-1:0] fn);
        logic [DATA_W-1:0]   word;
        logic [DATA_W-1:0]   parity;
        logic [FRAME_W-1:0]  rec_no;
        logic                rec_ok;
        int                  depth_before;
        word         = swap_octet_bits(raw);
        depth_before = expected_words.size();
        rec_no       = '0;
        rec_ok       = 1'b0;
        if (known && (fno % CTRL_PERIOD) == CTRL_RESIDUE) begin
            // control-channel frame: pass through, state untouched
            emit(KIND_CTRL, word, '0, fno, known, 1'b0, '0, 1'b0);
        end else begin
            case (msg_phase)
                ST_OPENED: begin
                    if (fn == FN_SINGLE || fn == FN_FIRST) begin
                        seq_error(1'b1);
                    end else if (fn == FN_CONT) begin
                        if (!stash(word)) seq_error(1'b1);
                        else msg_phase = ST_SECOND;
                    end else begin
                        // two-block message complete
                        held_blocks[1] = word;
                        emit(KIND_BLOCK, held_blocks[0], 4'd0, start_no, start_no_known,
                             1'b0, '0, 1'b0);
                        emit(KIND_BLOCK, word, 4'd1, start_no, start_no_known,
                             1'b0, '0, 1'b0);
                        msg_phase = ST_IDLE;
                    end
                end
                ST_SECOND, ST_BODY: begin
                    if (fn == FN_SINGLE || fn == FN_FIRST) begin
                        seq_error(msg_phase == ST_SECOND ? 1'b0 : 1'b1);
                    end else if (!stash(word)) begin
                        seq_error(1'b1);
                    end else begin
                        msg_phase = (fn == FN_CONT) ? ST_PARITY_DUE : ST_BODY;
                    end
                end
                ST_PARITY_DUE: begin
                    if (fn != FN_FIRST) begin
                        seq_error(1'b1);
                    end else if (!stash(word)) begin
                        seq_error(1'b1);
                    end else begin
                        msg_phase = ST_IDLE;
                        parity = '0;
                        for (int i = 0; i < blocks_held && i < BLOCK_SLOTS; i++) begin
                            parity ^= held_blocks[i];
                        end
                        if (parity != '0) begin
                            emit(KIND_PAR, '0, '0, start_no, start_no_known, 1'b0, '0, 1'b0);
                        end else begin
                            // infer the final frame number when it arrived unknown
                            if (!known && start_no_known) begin
                                rec_ok = 1'b1;
                                rec_no = FRAME_W'((int'(start_no) + blocks_held - 1)
                                                  % FRAMES_PER_MF);
                            end
                            for (int i = 0; i + 1 < blocks_held && i < BLOCK_SLOTS; i++) begin
                                emit(KIND_BLOCK, held_blocks[i], IDX_W'(i), start_no,
                                     start_no_known, 1'b0, rec_no, rec_ok);
                            end
                            if (blocks_held < 2) begin
                                emit(KIND_SEQ, '0, '0, start_no, start_no_known, 1'b1,
                                     '0, 1'b0);
                            end
                        end
                    end
                end
                default: begin
                    // idle: restart the message registers from this frame
                    blocks_held    = 0;
                    start_no       = fno;
                    start_no_known = known;
                    if (fn == FN_SINGLE) begin
                        held_blocks[0] = word;
                        emit(KIND_BLOCK, word, '0, fno, known, 1'b0, '0, 1'b0);
                        msg_phase = ST_IDLE;
                    end else if (fn == FN_FIRST) begin
                        held_blocks[0] = word;
                        blocks_held    = 1;
                        msg_phase      = ST_OPENED;
                    end else begin
                        seq_error(1'b1);
                    end
                end
            endcase
        end
        if (expected_words.size() > depth_before) begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [DATA_W-1:0] expv,
                                        input logic [DATA_W-1:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
            mismatches++;
        end
    endfunction

    // Compare one result word against the oldest expectation
    task automatic compare_word();
        result_word_t want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual kind %0d data %h",
                     $time, m_tuser, m_tdata);
            mismatches++;
        end else begin
            want = expected_words.pop_front();
            check_field("kind",            want.kind,        m_tuser);
            check_field("block_data",      want.data,        m_tdata[63:0]);
            check_field("block_index",     want.index,       m_tdata[67:64]);
            check_field("start_frame",     want.start_frame, m_tdata[75:68]);
            check_field("start_known",     want.start_known, m_tdata[76]);
            check_field("seg_reset",       want.seg_reset,   m_tdata[77]);
            check_field("recovered_frame", want.rec_frame,   m_tdata[85:78]);
            check_field("recovered_valid", want.rec_valid,   m_tdata[86]);
            check_field("last",            want.last,        m_tlast);
        end
    endtask

    // Watch both channels; frames first, then result words
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            msg_phase      = ST_IDLE;
            blocks_held    = 0;
            start_no       = '0;
            start_no_known = 1'b0;
            expected_words.delete();
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reassembly(s_tdata[63:0], s_tdata[71:64], s_tuser[0], s_tuser[2:1]);
            end
            if (m_tvalid && m_tready) begin
                compare_word();
            end
            fail_count <= mismatches;
            pending    <= expected_words.size();
        end
    end

endmodule

>>> dv/multiblock_frame_reassembler_top_tb.sv
// Testbench top for the multiblock frame reassembler: drives frames, throttles the result
// stream and gives the verdict. Depends on mfr_pkg, the block and mfr_reassembly_checker.
module multiblock_frame_reassembler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfr_pkg::*;

    localparam int BLOCK_SLOTS  = 16;
    localparam int ITEM_TARGET  = 460;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [S_TUSER_W-1:0]    s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    m_tlast;
    int                      fail_count;
    int                      pending;

    int                      send_idle_pct = 33;
    int                      recv_idle_pct = 52;
    int                      frames_sent = 0;
    int                      cycle_count = 0;
    logic [FRAME_W-1:0]      frame_cursor = '0;

    multiblock_frame_reassembler_top #(
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mfr_reassembly_checker #(
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Throttle the result stream
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Next frame number of a message, stepping over control slots; now and then a wild one
    function automatic logic [FRAME_W-1:0] take_frame_no();
        if ($urandom_range(99) < 5) begin
            return FRAME_W'($urandom_range(255));
        end
        frame_cursor = FRAME_W'((int'(frame_cursor) + 1) % FRAMES_PER_MF);
        if ((frame_cursor % CTRL_PERIOD) == CTRL_RESIDUE) begin
            frame_cursor++;
        end
        return frame_cursor;
    endfunction

    function automatic logic [FRAME_W-1:0] ctrl_frame_no();
        return FRAME_W'(CTRL_RESIDUE + CTRL_PERIOD * $urandom_range(9));
    endfunction

    // Offer one frame word, with a random gap first, and hold it until accepted
    task automatic send_frame(input logic [DATA_W-1:0] bits, input logic [FRAME_W-1:0] fno,
                              input logic known, input logic [FN_W-1:0] fn);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fno, bits};
        s_tuser  <= {fn, known};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        frames_sent++;
    endtask

    // Send a message frame, sometimes preceded by a stray control frame
    task automatic send_msg_frame(input logic [DATA_W-1:0] bits, input logic known,
                                  input logic [FN_W-1:0] fn);
        if ($urandom_range(99) < 5) begin
            send_frame(rand64(), ctrl_frame_no(), 1'b1, FN_W'($urandom_range(3)));
        end
        send_frame(bits, take_frame_no(), known, fn);
    endtask

    // Long message: first, continuation, end markers, continuation, then the parity block
    task automatic send_long_message(input int end_markers, input bit good_parity,
                                     input logic first_known, input logic last_known);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] bits;
        bits = rand64();
        acc  = bits;
        send_msg_frame(bits, first_known, FN_FIRST);
        bits = rand64();
        acc ^= bits;
        send_msg_frame(bits, $urandom_range(99) < 90, FN_CONT);
        repeat (end_markers) begin
            bits = rand64();
            acc ^= bits;
            send_msg_frame(bits, $urandom_range(99) < 90, FN_END);
        end
        bits = rand64();
        acc ^= bits;
        send_msg_frame(bits, $urandom_range(99) < 90, FN_CONT);
        if (!good_parity) begin
            acc ^= DATA_W'(1) << $urandom_range(DATA_W - 1);
        end
        send_msg_frame(acc, last_known, FN_FIRST);
    endtask

    initial begin
        int sel;
        int markers;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, control slots, each message shape and sequence error paths
        send_frame('1, 8'd0, 1'b1, FN_SINGLE);
        send_frame('0, 8'd199, 1'b0, FN_SINGLE);
        send_frame(64'h0123_4567_89ab_cdef, 8'd255, 1'b1, FN_SINGLE);
        send_frame(64'h8000_0000_0000_0001, 8'd14, 1'b1, FN_FIRST);
        send_frame(rand64(), 8'd239, 1'b1, FN_END);
        send_frame(rand64(), 8'd14, 1'b0, FN_SINGLE);
        send_frame(rand64(), 8'd20, 1'b1, FN_FIRST);
        send_frame(rand64(), 8'd21, 1'b1, FN_END);
        send_frame(rand64(), 8'd22, 1'b1, FN_CONT);
        send_frame(rand64(), 8'd23, 1'b0, FN_END);
        send_frame(rand64(), 8'd24, 1'b1, FN_FIRST);
        send_frame(rand64(), 8'd26, 1'b1, FN_SINGLE);
        frame_cursor = 8'd30;
        send_long_message(0, 1'b1, 1'b1, 1'b0);
        send_frame(rand64(), 8'd40, 1'b1, FN_FIRST);
        send_frame(rand64(), 8'd41, 1'b1, FN_CONT);
        send_frame(rand64(), 8'd42, 1'b1, FN_FIRST);
        send_long_message(1, 1'b0, 1'b1, 1'b1);

        // Random messages; swap the idle pattern by thirds, then run without idling
        while (frames_sent < ITEM_TARGET) begin
            if (frames_sent >= 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (frames_sent >= ITEM_TARGET / 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 33;
            end
            sel = $urandom_range(99);
            if (sel < 15) begin
                send_msg_frame(rand64(), $urandom_range(99) < 85, FN_SINGLE);
            end else if (sel < 30) begin
                send_msg_frame(rand64(), $urandom_range(99) < 85, FN_FIRST);
                send_msg_frame(rand64(), $urandom_range(99) < 85, FN_END);
            end else if (sel < 75) begin
                sel = $urandom_range(99);
                if (sel < 80) markers = $urandom_range(4);
                else if (sel < 92) markers = $urandom_range(11, 5);
                else markers = $urandom_range(14, 12);
                send_long_message(markers, $urandom_range(99) < 85,
                                  $urandom_range(99) < 85, $urandom_range(99) < 50);
            end else if (sel < 90) begin
                // broken sequence: a proper opening, then random function codes
                send_msg_frame(rand64(), 1'b1, FN_FIRST);
                send_msg_frame(rand64(), 1'b1, FN_CONT);
                repeat ($urandom_range(3)) begin
                    send_msg_frame(rand64(), $urandom_range(1), FN_W'($urandom_range(3)));
                end
            end else begin
                send_frame(rand64(), ctrl_frame_no(), 1'b1, FN_W'($urandom_range(3)));
            end
        end
        s_tvalid <= 1'b0;

        // Let the checker count the last frame, drain outstanding results, then settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mfr_pkg.sv
hdl/mfr_ram.sv
hdl/mfr_msg_ctrl.sv
hdl/mfr_sweep.sv
hdl/multiblock_frame_reassembler_top.sv
dv/mfr_reassembly_checker.sv
dv/multiblock_frame_reassembler_top_tb.sv
